// ----- src/acksw_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the six-wheel steering block.
// Used by every module of the block; depends on nothing.
package acksw_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ITERATIONS  = 16;
   localparam int ATAN_LEN    = 24;

   // CORDIC datapath widths (Q16 millimetres and Q16 radians).
   localparam int CX_W        = 38;
   localparam int CZ_W        = 20;
   localparam int THETA_W     = 17;

   // Shared restoring divider geometry.
   localparam int DIV_NUM_W   = 54;
   localparam int DIV_DEN_W   = 35;
   localparam int DIV_QB      = 35;
   localparam int DIV_LAT     = DIV_QB + 1;

   // Back end pipeline depth, from the rotation CORDIC to the speed stage.
   localparam int BACK_STAGES = ITERATIONS + 1 + DIV_LAT + 1 + ITERATIONS + 1
                                + DIV_LAT + 1 + 1;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;

   localparam int RSP_W       = 112;

   localparam logic [24:0] DEG_Q30          = 25'd18740330;
   localparam logic [25:0] RAD_TO_16DEG_Q16 = 26'd60078979;
   localparam logic [29:0] INV_GAIN_Q30     = 30'd652032874;
   localparam logic [34:0] R_MAX            = 35'h4_0000_0000;
   localparam logic [34:0] RATIO_SAT        = 35'd134217728;
   localparam logic [10:0] ANGLE_MAX        = 11'd1440;
   localparam logic [9:0]  SPEED_MAX        = 10'd1023;
   localparam logic [6:0]  STEER_MIN        = 7'd1;
   localparam logic [6:0]  STEER_MAX        = 7'd89;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_TRACK_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_FRONT_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_REAR_LENGTH   = 3'd2;
   localparam logic [2:0] CSR_STRAIGHT_BAND = 3'd3;
   localparam logic [2:0] CSR_STEER_LIMIT   = 3'd4;
   localparam logic [2:0] CSR_LEFT_FORWARD  = 3'd5;

   localparam logic [10:0] RST_TRACK_WIDTH   = 11'd537;
   localparam logic [10:0] RST_FRONT_LENGTH  = 11'd302;
   localparam logic [10:0] RST_REAR_LENGTH   = 11'd278;
   localparam logic [6:0]  RST_STRAIGHT_BAND = 7'd10;
   localparam logic [6:0]  RST_STEER_LIMIT   = 7'd80;
   localparam logic        RST_LEFT_FORWARD  = 1'b1;

   // atan(2^-i) in Q30, truncated.
   localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
   };

   typedef struct packed {
      logic [10:0] track_width;
      logic [10:0] front_length;
      logic [10:0] rear_length;
      logic [6:0]  straight_band;
      logic [6:0]  steer_limit;
      logic        left_forward;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         drive;
      logic               turn;
      logic               left;
      logic [THETA_W-1:0] theta;
   } item_type;

   typedef struct packed {
      logic [7:0] drive;
      logic       turn;
      logic       left;
   } ctrl_type;

   // Table angle rounded to Q(FRAC_BITS).
   function automatic logic signed [CZ_W-1:0] atan_step(input int idx);
      logic [30:0] t;
      t = {1'b0, ATAN_Q30[idx]} + 31'(1 << (29 - FRAC_BITS));
      return CZ_W'(t >> (30 - FRAC_BITS));
   endfunction

endpackage

// ----- src/ackermann_six_wheel_steering.sv -----
// Path: a request passes the front end register, 1 queue stage, 109 back end pipeline
// stages and the response register; a stall holds it where it stands.
// Throughput: one request per cycle, set by the fully pipelined CORDICs and the
// one-bit-per-stage dividers; the back end stalls only when its response is not taken.
// Reset (synchronous, active high) empties front, queue and pipeline and loads the
// register defaults; a configuration write in a reset cycle is ignored.
module ackermann_six_wheel_steering (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // drive_speed[7:0], steer_angle[15:8]
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // servo_front_left[11:0], servo_front_right[23:12], servo_rear_left[35:24],
   // servo_rear_right[47:36], speed_front_left[57:48], speed_front_right[67:58],
   // speed_mid_left[77:68], speed_mid_right[87:78], speed_rear_left[97:88],
   // speed_rear_right[107:98], left_direction[108], right_direction[109], zero[111:110]
   output logic [acksw_pkg::RSP_W-1:0] rsp_tdata,
   // Configuration write port.
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [10:0]                 csr_wdata
);

   acksw_pkg::cfg_type  cfg_ff, cfg_in;
   logic                front_valid, front_ready;
   acksw_pkg::item_type front_item;
   logic                queue_valid, queue_ready;
   acksw_pkg::item_type queue_item;

   // Register file. Writes to unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            acksw_pkg::CSR_TRACK_WIDTH:   cfg_in.track_width   = csr_wdata;
            acksw_pkg::CSR_FRONT_LENGTH:  cfg_in.front_length  = csr_wdata;
            acksw_pkg::CSR_REAR_LENGTH:   cfg_in.rear_length   = csr_wdata;
            acksw_pkg::CSR_STRAIGHT_BAND: cfg_in.straight_band = csr_wdata[6:0];
            acksw_pkg::CSR_STEER_LIMIT:   cfg_in.steer_limit   = csr_wdata[6:0];
            acksw_pkg::CSR_LEFT_FORWARD:  cfg_in.left_forward  = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_width   <= acksw_pkg::RST_TRACK_WIDTH;
         cfg_ff.front_length  <= acksw_pkg::RST_FRONT_LENGTH;
         cfg_ff.rear_length   <= acksw_pkg::RST_REAR_LENGTH;
         cfg_ff.straight_band <= acksw_pkg::RST_STRAIGHT_BAND;
         cfg_ff.steer_limit   <= acksw_pkg::RST_STEER_LIMIT;
         cfg_ff.left_forward  <= acksw_pkg::RST_LEFT_FORWARD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end classifies each request and clamps its angle.
   acksw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_data  (req_tdata),
      .req_ready (req_tready),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_ready (front_ready)
   );

   // The queue lets the front end keep accepting while the back end is stalled.
   acksw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_ready  (queue_ready)
   );

   // Back end computes the geometry and holds the response register.
   acksw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (queue_valid),
      .in_item   (queue_item),
      .in_ready  (queue_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready)
   );

endmodule

// ----- src/acksw_front.sv -----
// Front end: takes a request, decides straight, right or left and works out the
// clamped steering angle in Q16 radians. Depends on acksw_pkg.
module acksw_front (
   input  logic               clock,
   input  logic               reset,
   input  acksw_pkg::cfg_type cfg,
   input  logic               req_valid,
   input  logic [15:0]        req_data,
   output logic               req_ready,
   output logic               out_valid,
   output acksw_pkg::item_type out_item,
   input  logic               out_ready
);

   logic                  valid_ff, valid_in;
   acksw_pkg::item_type   item_ff, item_in;
   logic signed [8:0]     ang, band, neg_band;
   logic [7:0]            mag_abs;
   logic [6:0]            lim, mag;
   logic [31:0]           theta_prod;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      ang      = {req_data[15], req_data[15:8]};
      band     = {2'b00, cfg.straight_band};
      neg_band = 9'sd0 - band;
      mag_abs  = ang[8] ? 8'(9'd0 - ang) : ang[7:0];
      if (cfg.steer_limit < acksw_pkg::STEER_MIN) begin
         lim = acksw_pkg::STEER_MIN;
      end else if (cfg.steer_limit > acksw_pkg::STEER_MAX) begin
         lim = acksw_pkg::STEER_MAX;
      end else begin
         lim = cfg.steer_limit;
      end
      mag = (mag_abs > {1'b0, lim}) ? lim : mag_abs[6:0];
      theta_prod = 32'(mag) * 32'(acksw_pkg::DEG_Q30);
      item_in.drive = req_data[7:0];
      item_in.turn  = (ang > band) || (ang < neg_band);
      item_in.left  = ang < neg_band;
      item_in.theta = acksw_pkg::THETA_W'((theta_prod + 32'(1 << (29 - acksw_pkg::FRAC_BITS)))
                                          >> (30 - acksw_pkg::FRAC_BITS));
      valid_in = req_valid ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      if (!req_ready) begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- src/acksw_fifo.sv -----
// Short request queue between the front end and the back end pipeline.
// Depends on acksw_pkg for the item type and depth.
module acksw_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  acksw_pkg::item_type push_item,
   output logic                push_ready,
   output logic                pop_valid,
   output acksw_pkg::item_type pop_item,
   input  logic                pop_ready
);

   acksw_pkg::item_type              mem_ff [acksw_pkg::FIFO_DEPTH];
   logic [acksw_pkg::FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [acksw_pkg::FIFO_AW:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = count_ff != (acksw_pkg::FIFO_AW + 1)'(acksw_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/acksw_cordic.sv -----
// Pipelined CORDIC, one iteration per stage, in rotation or vectoring mode.
// Depends on acksw_pkg for widths, iteration count and the angle table.
module acksw_cordic (
   input  logic                                clock,
   input  logic                                en,
   input  logic                                vectoring,
   input  logic signed [acksw_pkg::CX_W-1:0]   src_x,
   input  logic signed [acksw_pkg::CX_W-1:0]   src_y,
   input  logic signed [acksw_pkg::CZ_W-1:0]   src_z,
   output logic signed [acksw_pkg::CX_W-1:0]   res_x,
   output logic signed [acksw_pkg::CX_W-1:0]   res_y,
   output logic signed [acksw_pkg::CZ_W-1:0]   res_z
);

   localparam int N = acksw_pkg::ITERATIONS;

   logic signed [acksw_pkg::CX_W-1:0] x_ff [N];
   logic signed [acksw_pkg::CX_W-1:0] y_ff [N];
   logic signed [acksw_pkg::CZ_W-1:0] z_ff [N];
   logic signed [acksw_pkg::CX_W-1:0] x_in [N];
   logic signed [acksw_pkg::CX_W-1:0] y_in [N];
   logic signed [acksw_pkg::CZ_W-1:0] z_in [N];
   logic signed [acksw_pkg::CX_W-1:0] x_cur [N];
   logic signed [acksw_pkg::CX_W-1:0] y_cur [N];
   logic signed [acksw_pkg::CZ_W-1:0] z_cur [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_step
         logic pos;
         if (i == 0) begin : g_first
            assign x_cur[i] = src_x;
            assign y_cur[i] = src_y;
            assign z_cur[i] = src_z;
         end else begin : g_next
            assign x_cur[i] = x_ff[i-1];
            assign y_cur[i] = y_ff[i-1];
            assign z_cur[i] = z_ff[i-1];
         end
         // Positive rotation: toward +z in rotation mode, toward y = 0 from below in vectoring.
         assign pos     = vectoring ? (y_cur[i] <= 0) : (z_cur[i] >= 0);
         assign x_in[i] = pos ? x_cur[i] - (y_cur[i] >>> i) : x_cur[i] + (y_cur[i] >>> i);
         assign y_in[i] = pos ? y_cur[i] + (x_cur[i] >>> i) : y_cur[i] - (x_cur[i] >>> i);
         assign z_in[i] = pos ? z_cur[i] - acksw_pkg::atan_step(i)
                              : z_cur[i] + acksw_pkg::atan_step(i);
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i] <= x_in[i];
               y_ff[i] <= y_in[i];
               z_ff[i] <= z_in[i];
            end
         end
      end
   endgenerate

   assign res_x = x_ff[N-1];
   assign res_y = y_ff[N-1];
   assign res_z = z_ff[N-1];

endmodule

// ----- src/acksw_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating to all ones.
// Depends on acksw_pkg for its widths.
module acksw_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [acksw_pkg::DIV_NUM_W-1:0]   num,
   input  logic [acksw_pkg::DIV_DEN_W-1:0]   den,
   output logic [acksw_pkg::DIV_QB-1:0]      quo
);

   localparam int QB = acksw_pkg::DIV_QB;
   localparam int NW = acksw_pkg::DIV_NUM_W;
   localparam int DW = acksw_pkg::DIV_DEN_W;

   logic [NW-1:0] num_ff [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic [DW-1:0] rem_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic          ovf_ff [QB+1];

   // Entry stage: flag quotients that do not fit and seed the remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= num;
         den_ff[0] <= den;
         ovf_ff[0] <= (num >> QB) >= NW'(den);
         rem_ff[0] <= DW'(num >> QB);
         quo_ff[0] <= '0;
      end
   end

   genvar k;
   generate
      for (k = 0; k < QB; k++) begin : g_bit
         logic [DW:0]   trial;
         logic          fits;
         logic [DW-1:0] rem_in;
         assign trial  = {rem_ff[k], num_ff[k][QB-1-k]};
         assign fits   = trial >= {1'b0, den_ff[k]};
         assign rem_in = fits ? DW'(trial - {1'b0, den_ff[k]}) : DW'(trial);
         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[k+1] <= num_ff[k];
               den_ff[k+1] <= den_ff[k];
               ovf_ff[k+1] <= ovf_ff[k];
               rem_ff[k+1] <= rem_in;
               quo_ff[k+1] <= {quo_ff[k][QB-2:0], fits};
            end
         end
      end
   endgenerate

   assign quo = ovf_ff[QB] ? '1 : quo_ff[QB];

endmodule

// ----- src/acksw_back.sv -----
// Back end: radius from a rotation CORDIC and a divider, wheel angles from vectoring
// CORDICs, wheel speeds from dividers and multipliers. Depends on acksw_pkg,
// acksw_cordic and acksw_div.
module acksw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  acksw_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   input  acksw_pkg::item_type           in_item,
   output logic                          in_ready,
   output logic                          out_valid,
   output logic [acksw_pkg::RSP_W-1:0]   out_data,
   input  logic                          out_ready
);

   localparam int NS  = acksw_pkg::BACK_STAGES;
   localparam int IT  = acksw_pkg::ITERATIONS;
   localparam int DL  = acksw_pkg::DIV_LAT;
   localparam int XW  = acksw_pkg::CX_W;
   localparam int ZW  = acksw_pkg::CZ_W;
   localparam int F   = acksw_pkg::FRAC_BITS;
   localparam logic signed [XW-1:0] X_ONE = XW'(1 << F);

   logic                   en;
   logic                   vld_ff [NS];
   acksw_pkg::ctrl_type    ctrl_ff [NS];
   logic                   out_valid_ff;
   logic [acksw_pkg::RSP_W-1:0] out_data_ff, out_data_in;

   // Every stage moves together whenever the output register can take a value.
   assign en        = !out_valid_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctrl_ff[0] <= '{drive: in_item.drive, turn: in_item.turn, left: in_item.left};
         for (int k = 1; k < NS; k++) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
   end

   // Rotation CORDIC: cos and sin of the steering angle, both scaled by the CORDIC gain.
   logic signed [XW-1:0] rot_x, rot_y;
   logic signed [ZW-1:0] rot_z;

   acksw_cordic u_rot (
      .clock     (clock),
      .en        (en),
      .vectoring (1'b0),
      .src_x     (X_ONE),
      .src_y     ('0),
      .src_z     (ZW'(signed'({1'b0, in_item.theta}))),
      .res_x     (rot_x),
      .res_y     (rot_y),
      .res_z     (rot_z)
   );

   // Stage P1: front_length * cos, with cos held at zero or more and sin at one or more.
   logic [16:0] c_cl, s_cl;
   logic [27:0] prod1_ff, prod1_in;
   logic [16:0] s1_ff;

   always_comb begin
      c_cl     = (rot_x < 0) ? 17'd0 : rot_x[16:0];
      s_cl     = (rot_y < 1) ? 17'd1 : rot_y[16:0];
      prod1_in = 28'(cfg.front_length) * 28'(c_cl);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= prod1_in;
         s1_ff    <= s_cl;
      end
   end

   logic [acksw_pkg::DIV_QB-1:0] quo1;

   acksw_div u_div_radius (
      .clock (clock),
      .en    (en),
      .num   ({10'b0, prod1_ff, 16'b0}),
      .den   ({18'b0, s1_ff}),
      .quo   (quo1)
   );

   // Stage P2: saturate and floor the radius, then the inner and outer radii.
   logic [34:0] half, floor_r, r_sat, r_fl;
   logic [34:0] r2_ff, inner2_ff, outer2_ff;

   always_comb begin
      half    = {9'b0, cfg.track_width, 15'b0};
      floor_r = half + 35'(1 << F);
      r_sat   = (quo1 > acksw_pkg::R_MAX) ? acksw_pkg::R_MAX : quo1;
      r_fl    = (r_sat < floor_r) ? floor_r : r_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff     <= r_fl;
         inner2_ff <= r_fl - half;
         outer2_ff <= r_fl + half;
      end
   end

   // Radii ride beside the vectoring CORDICs.
   logic [34:0] r_d_ff [IT];
   logic [34:0] inner_d_ff [IT];
   logic [34:0] outer_d_ff [IT];

   always_ff @(posedge clock) begin
      if (en) begin
         r_d_ff[0]     <= r2_ff;
         inner_d_ff[0] <= inner2_ff;
         outer_d_ff[0] <= outer2_ff;
         for (int k = 1; k < IT; k++) begin
            r_d_ff[k]     <= r_d_ff[k-1];
            inner_d_ff[k] <= inner_d_ff[k-1];
            outer_d_ff[k] <= outer_d_ff[k-1];
         end
      end
   end

   // Vectoring lanes: front inner, front outer, rear inner, rear outer.
   logic signed [XW-1:0] vx_src [4];
   logic signed [XW-1:0] vy_src [4];
   logic signed [XW-1:0] vec_x [4];
   logic signed [XW-1:0] vec_y [4];
   logic signed [ZW-1:0] vec_z [4];

   assign vx_src[0] = {3'b0, inner2_ff};
   assign vx_src[1] = {3'b0, outer2_ff};
   assign vx_src[2] = {3'b0, inner2_ff};
   assign vx_src[3] = {3'b0, outer2_ff};
   assign vy_src[0] = {11'b0, cfg.front_length, 16'b0};
   assign vy_src[1] = {11'b0, cfg.front_length, 16'b0};
   assign vy_src[2] = {11'b0, cfg.rear_length, 16'b0};
   assign vy_src[3] = {11'b0, cfg.rear_length, 16'b0};

   // Stage P3 registers.
   logic [44:0] aprod_ff [4];
   logic [36:0] mag_ff [4];
   logic [34:0] r3_ff, inner3_ff;
   logic [3:0][10:0] ang_now;

   genvar v;
   generate
      for (v = 0; v < 4; v++) begin : g_vec
         logic [18:0] zc;
         logic [45:0] arnd;
         logic [13:0] ashift;

         acksw_cordic u_vec (
            .clock     (clock),
            .en        (en),
            .vectoring (1'b1),
            .src_x     (vx_src[v]),
            .src_y     (vy_src[v]),
            .src_z     ('0),
            .res_x     (vec_x[v]),
            .res_y     (vec_y[v]),
            .res_z     (vec_z[v])
         );

         assign zc = (vec_z[v] < 0) ? 19'd0 : vec_z[v][18:0];

         always_ff @(posedge clock) begin
            if (en) begin
               aprod_ff[v] <= 45'(zc) * 45'(acksw_pkg::RAD_TO_16DEG_Q16);
               mag_ff[v]   <= (vec_x[v] < 0) ? 37'd0 : vec_x[v][36:0];
            end
         end

         // Radians to 1/16 degree, rounded, capped at 90 degrees.
         assign arnd   = {1'b0, aprod_ff[v]} + 46'(64'd1 << (F + 15));
         assign ashift = 14'(arnd >> (F + 16));
         assign ang_now[v] = (ashift > 14'(acksw_pkg::ANGLE_MAX)) ? acksw_pkg::ANGLE_MAX
                                                                 : ashift[10:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         r3_ff     <= r_d_ff[IT-1];
         inner3_ff <= inner_d_ff[IT-1];
      end
   end

   logic [34:0] outer3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         outer3_ff <= outer_d_ff[IT-1];
      end
   end

   // Angles ride beside the speed dividers.
   logic [3:0][10:0] ang_d_ff [DL];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_d_ff[0] <= ang_now;
         for (int k = 1; k < DL; k++) begin
            ang_d_ff[k] <= ang_d_ff[k-1];
         end
      end
   end

   // Speed ratio lanes: four corner wheels, then middle inner and middle outer.
   logic [acksw_pkg::DIV_NUM_W-1:0] dnum [6];
   logic [acksw_pkg::DIV_QB-1:0]    dquo [6];
   logic [27:0]                     rg_ff [6];
   logic [27:0]                     rg_in [6];
   logic [9:0]                      sp6_ff [6];
   logic [3:0][10:0]                ang5_ff, ang6_ff;

   assign dnum[0] = {1'b0, mag_ff[0], 16'b0};
   assign dnum[1] = {1'b0, mag_ff[1], 16'b0};
   assign dnum[2] = {1'b0, mag_ff[2], 16'b0};
   assign dnum[3] = {1'b0, mag_ff[3], 16'b0};
   assign dnum[4] = {3'b0, inner3_ff, 16'b0};
   assign dnum[5] = {3'b0, outer3_ff, 16'b0};

   genvar w;
   generate
      for (w = 0; w < 6; w++) begin : g_speed
         logic [27:0] qs;
         logic [57:0] gprod;
         logic [35:0] dprod;
         logic [19:0] sp_raw;

         acksw_div u_div_ratio (
            .clock (clock),
            .en    (en),
            .num   (dnum[w]),
            .den   (r3_ff),
            .quo   (dquo[w])
         );

         // Any ratio this large already saturates the speed for a nonzero drive.
         assign qs = (dquo[w] >= acksw_pkg::RATIO_SAT) ? 28'(acksw_pkg::RATIO_SAT)
                                                       : dquo[w][27:0];
         if (w < 4) begin : g_corner
            assign gprod    = 58'(qs) * 58'(acksw_pkg::INV_GAIN_Q30);
            assign rg_in[w] = 28'(gprod >> 30);
         end else begin : g_mid
            assign gprod    = '0;
            assign rg_in[w] = qs;
         end

         assign dprod  = 36'(ctrl_ff[NS-2].drive) * 36'(rg_ff[w]);
         assign sp_raw = 20'(dprod >> 16);

         always_ff @(posedge clock) begin
            if (en) begin
               rg_ff[w]  <= rg_in[w];
               sp6_ff[w] <= (sp_raw > 20'(acksw_pkg::SPEED_MAX)) ? acksw_pkg::SPEED_MAX
                                                                 : sp_raw[9:0];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         ang5_ff <= ang_d_ff[DL-1];
         ang6_ff <= ang5_ff;
      end
   end

   // Output stage: mirror for left turns, straight items keep the servos at zero and every speed at the drive value.
   logic [11:0] pos_fi, pos_ri, neg_fo, neg_ro;
   logic [11:0] sv_fl, sv_fr, sv_rl, sv_rr;
   logic [9:0]  sp_fl, sp_fr, sp_ml, sp_mr, sp_rl, sp_rr;
   acksw_pkg::ctrl_type last;

   always_comb begin
      last   = ctrl_ff[NS-1];
      pos_fi = {1'b0, ang6_ff[0]};
      neg_fo = 12'd0 - {1'b0, ang6_ff[1]};
      pos_ri = {1'b0, ang6_ff[2]};
      neg_ro = 12'd0 - {1'b0, ang6_ff[3]};
      if (!last.turn) begin
         sv_fl = '0; sv_fr = '0; sv_rl = '0; sv_rr = '0;
         sp_fl = {2'b0, last.drive};
         sp_fr = {2'b0, last.drive};
         sp_ml = {2'b0, last.drive};
         sp_mr = {2'b0, last.drive};
         sp_rl = {2'b0, last.drive};
         sp_rr = {2'b0, last.drive};
      end else if (!last.left) begin
         sv_fl = neg_fo; sv_fr = pos_fi; sv_rl = neg_ro; sv_rr = pos_ri;
         sp_fl = sp6_ff[1]; sp_fr = sp6_ff[0];
         sp_ml = sp6_ff[5]; sp_mr = sp6_ff[4];
         sp_rl = sp6_ff[3]; sp_rr = sp6_ff[2];
      end else begin
         sv_fl = pos_fi; sv_fr = neg_fo; sv_rl = pos_ri; sv_rr = neg_ro;
         sp_fl = sp6_ff[0]; sp_fr = sp6_ff[1];
         sp_ml = sp6_ff[4]; sp_mr = sp6_ff[5];
         sp_rl = sp6_ff[2]; sp_rr = sp6_ff[3];
      end
      out_data_in = {2'b00, !cfg.left_forward, cfg.left_forward,
                     sp_rr, sp_rl, sp_mr, sp_ml, sp_fr, sp_fl,
                     sv_rr, sv_rl, sv_fr, sv_fl};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
